[hw/rtl/lhc_pkg.sv]
// Package for the latency histogram collector: widths, operation codes,
// the bin edge table and shared helper functions. No dependencies.
package lhc_pkg;

  localparam int NUM_BINS   = 33;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int EDGE_COUNT = 32;

  localparam int OP_W   = 2;
  localparam int LAT_W  = 32;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 48;
  localparam int SUM_W  = 64;

  // Depth of the result queue; the input side is throttled so it never overflows.
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [OP_W-1:0]  op_t;
  typedef logic [LAT_W-1:0] lat_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [BIN_W-1:0] bin_t;

  // Code 3 is unused and behaves as a read.
  localparam op_t OP_RECORD = 2'd0;
  localparam op_t OP_CLEAR  = 2'd2;

  localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

  localparam lat_t EDGE [EDGE_COUNT] = '{
    32'd10, 32'd50, 32'd100, 32'd200, 32'd500,
    32'd1000, 32'd2000, 32'd3000, 32'd4000, 32'd5000, 32'd6000, 32'd7000,
    32'd8000, 32'd9000,
    32'd10000, 32'd20000, 32'd40000, 32'd60000, 32'd80000,
    32'd100000, 32'd200000, 32'd300000, 32'd400000, 32'd500000, 32'd600000,
    32'd700000, 32'd800000, 32'd900000,
    32'd1000000, 32'd2000000, 32'd4000000, 32'd8000000
  };

  typedef struct packed {
    cnt_t sample_count;
    sum_t latency_sum;
    lat_t min_latency;
    lat_t max_latency;
    cnt_t bin_count;
    idx_t bin_echo;
  } rsp_t;

  // Bins past the end of the table have an edge at the largest latency.
  function automatic lat_t edge_of(input int b);
    lat_t e;
    e = '1;
    if (b < EDGE_COUNT) begin
      e = EDGE[b];
    end
    return e;
  endfunction

  function automatic cnt_t sat_inc(input cnt_t v);
    cnt_t r;
    r = (v == CNT_MAX) ? CNT_MAX : v + cnt_t'(1);
    return r;
  endfunction

endpackage

[hw/rtl/lhc_req_if.sv]
// Request channel of the latency histogram collector: valid/ready plus
// the item fields. Depends on lhc_pkg.
interface lhc_req_if;
  logic          valid;
  logic          ready;
  lhc_pkg::op_t  op;
  lhc_pkg::lat_t latency;
  lhc_pkg::idx_t bin_index;

  modport source (output valid, output op, output latency, output bin_index, input ready);
  modport sink   (input valid, input op, input latency, input bin_index, output ready);
endinterface

[hw/rtl/lhc_rsp_if.sv]
// Result channel of the latency histogram collector: valid/ready plus
// the statistics fields. Depends on lhc_pkg.
interface lhc_rsp_if;
  logic          valid;
  logic          ready;
  lhc_pkg::cnt_t sample_count;
  lhc_pkg::sum_t latency_sum;
  lhc_pkg::lat_t min_latency;
  lhc_pkg::lat_t max_latency;
  lhc_pkg::cnt_t bin_count;
  lhc_pkg::idx_t bin_echo;

  modport source (output valid, output sample_count, output latency_sum, output min_latency,
                  output max_latency, output bin_count, output bin_echo, input ready);
  modport sink   (input valid, input sample_count, input latency_sum, input min_latency,
                  input max_latency, input bin_count, input bin_echo, output ready);
endinterface

[hw/rtl/lhc_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered reads
// that return the old contents on a same-cycle write. No dependencies.
module lhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hw/rtl/lhc_bin_sel.sv]
// Bin selection: compares a latency against every bin edge in parallel and
// picks the first bin whose edge covers it. Depends on lhc_pkg.
module lhc_bin_sel (
  input  lhc_pkg::lat_t lat,
  output lhc_pkg::bin_t bin
);

  always_comb begin
    bin = lhc_pkg::bin_t'(lhc_pkg::NUM_BINS - 1);
    // Walk downward so the lowest matching edge wins.
    for (int b = lhc_pkg::NUM_BINS - 2; b >= 0; b--) begin
      if (lat <= lhc_pkg::edge_of(b)) begin
        bin = lhc_pkg::bin_t'(b);
      end
    end
  end

endmodule

[hw/rtl/lhc_out_fifo.sv]
// Result queue of the latency histogram collector: a few register entries
// that decouple the update stage from the result channel. Depends on
// lhc_pkg and lhc_rsp_if.
module lhc_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  lhc_pkg::rsp_t                 push_data,
  output logic [lhc_pkg::FIFO_CNT_W-1:0] count,
  lhc_rsp_if.source                     rsp
);

  lhc_pkg::rsp_t                   entries [lhc_pkg::FIFO_DEPTH];
  logic [lhc_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [lhc_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic                            pop;
  lhc_pkg::rsp_t                   head;

  function automatic logic [lhc_pkg::FIFO_PTR_W-1:0] ptr_inc(
    input logic [lhc_pkg::FIFO_PTR_W-1:0] p
  );
    logic [lhc_pkg::FIFO_PTR_W-1:0] r;
    r = (p == lhc_pkg::FIFO_PTR_W'(lhc_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign pop  = rsp.valid && rsp.ready;
  assign head = entries[rd_ptr];

  assign rsp.valid        = (count != '0);
  assign rsp.sample_count = head.sample_count;
  assign rsp.latency_sum  = head.latency_sum;
  assign rsp.min_latency  = head.min_latency;
  assign rsp.max_latency  = head.max_latency;
  assign rsp.bin_count    = head.bin_count;
  assign rsp.bin_echo     = head.bin_echo;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/latency_histogram_collector.sv]
// Latency histogram collector, top level. Depends on lhc_pkg, lhc_req_if,
// lhc_rsp_if, lhc_ram, lhc_bin_sel and lhc_out_fifo.
//
// Usage: each request item carries op (record, read or clear), a latency
// in microseconds and a bin index. Every item returns exactly one result
// item with the sample count, the latency sum, min, max and the count of
// the requested bin, all taken after the item has been applied.
// The bin RAM is read at the edge that accepts a request; the update and
// write-back happen in the update stage, and the result enters the queue
// at the end of that stage.
// Throughput: one item per cycle, set by the bin RAM's single write port, while
// the queue has room; a record to the previous item's bin is served by forwarding.
// Reset (rst, synchronous) clears all statistics at once: the bins carry
// one valid bit each, so no clearing pass runs and items are accepted in
// the first cycle after reset. A clear item works the same way.
// When the receiver stalls, results collect in a three-entry queue and
// ready drops only once the queue plus the item in flight fill it; no
// result is lost or repeated.
module latency_histogram_collector (
  input  logic      clk,
  input  logic      rst,
  lhc_req_if.sink   req,
  lhc_rsp_if.source rsp
);

  logic                            accept;
  lhc_pkg::bin_t                   pick_bin;
  logic                            idx_ok;
  lhc_pkg::bin_t                   idx_addr;
  logic [lhc_pkg::FIFO_CNT_W-1:0]  fifo_count;

  // Valid bit per bin; a bin without it reads as zero.
  logic [lhc_pkg::NUM_BINS-1:0]    vbits;

  // Update stage.
  logic                            s1_valid;
  lhc_pkg::op_t                    s1_op;
  lhc_pkg::lat_t                   s1_lat;
  lhc_pkg::bin_t                   s1_bin;
  lhc_pkg::idx_t                   s1_idx;
  logic                            s1_idx_ok;
  logic                            s1_vb_bin;
  logic                            s1_vb_idx;

  // What the update stage did in the cycle the current reads were issued.
  logic                            wr_last;
  lhc_pkg::bin_t                   wr_addr;
  lhc_pkg::cnt_t                   wr_data;
  logic                            clr_last;

  lhc_pkg::cnt_t                   q_bin;
  lhc_pkg::cnt_t                   q_idx;
  lhc_pkg::cnt_t                   bin_cur;
  lhc_pkg::cnt_t                   idx_cur;
  lhc_pkg::cnt_t                   bin_new;
  logic                            is_record;
  logic                            is_clear;
  logic                            ram_we;

  lhc_pkg::cnt_t                   count;
  lhc_pkg::cnt_t                   count_next;
  lhc_pkg::sum_t                   sum;
  lhc_pkg::sum_t                   sum_next;
  lhc_pkg::lat_t                   min_lat;
  lhc_pkg::lat_t                   min_lat_next;
  lhc_pkg::lat_t                   max_lat;
  lhc_pkg::lat_t                   max_lat_next;
  lhc_pkg::cnt_t                   bin_report;
  lhc_pkg::rsp_t                   result;

  assign accept = req.valid && req.ready;
  // The queue always has room for the item in flight and one more.
  assign req.ready = (32'(fifo_count) + 32'(s1_valid)) < lhc_pkg::FIFO_DEPTH;

  lhc_bin_sel u_bin_sel (
    .lat (req.latency),
    .bin (pick_bin)
  );

  assign idx_ok   = 32'(req.bin_index) < lhc_pkg::NUM_BINS;
  assign idx_addr = idx_ok ? req.bin_index[lhc_pkg::BIN_W-1:0] : '0;

  lhc_ram #(
    .WIDTH (lhc_pkg::CNT_W),
    .DEPTH (lhc_pkg::NUM_BINS)
  ) u_bin_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (s1_bin),
    .wdata   (bin_new),
    .raddr_a (pick_bin),
    .rdata_a (q_bin),
    .raddr_b (idx_addr),
    .rdata_b (q_idx)
  );

  always_ff @(posedge clk) begin
    s1_op     <= req.op;
    s1_lat    <= req.latency;
    s1_bin    <= pick_bin;
    s1_idx    <= req.bin_index;
    s1_idx_ok <= idx_ok;
    s1_vb_bin <= vbits[pick_bin];
    s1_vb_idx <= vbits[idx_addr];
    wr_addr   <= s1_bin;
    wr_data   <= bin_new;
  end

  assign is_record = s1_valid && (s1_op == lhc_pkg::OP_RECORD);
  assign is_clear  = s1_valid && (s1_op == lhc_pkg::OP_CLEAR);
  assign ram_we    = is_record;

  // Bin values as seen after the previous item: a clear or a write made at the
  // edge that issued the reads has not reached the read data yet.
  always_comb begin
    if (clr_last) begin
      bin_cur = '0;
    end else if (wr_last && (wr_addr == s1_bin)) begin
      bin_cur = wr_data;
    end else begin
      bin_cur = s1_vb_bin ? q_bin : '0;
    end

    if (clr_last) begin
      idx_cur = '0;
    end else if (wr_last && (wr_addr == s1_idx[lhc_pkg::BIN_W-1:0])) begin
      idx_cur = wr_data;
    end else begin
      idx_cur = s1_vb_idx ? q_idx : '0;
    end
  end

  assign bin_new = lhc_pkg::sat_inc(bin_cur);

  always_comb begin
    count_next   = count;
    sum_next     = sum;
    min_lat_next = min_lat;
    max_lat_next = max_lat;
    if (is_record) begin
      count_next = lhc_pkg::sat_inc(count);
      sum_next   = sum + lhc_pkg::sum_t'(s1_lat);
      // A zero minimum means none recorded yet.
      if ((min_lat == '0) || (min_lat > s1_lat)) begin
        min_lat_next = s1_lat;
      end
      if (max_lat < s1_lat) begin
        max_lat_next = s1_lat;
      end
    end else if (is_clear) begin
      count_next   = '0;
      sum_next     = '0;
      min_lat_next = '0;
      max_lat_next = '0;
    end
  end

  always_comb begin
    if (!s1_idx_ok || is_clear) begin
      bin_report = '0;
    end else if (is_record && (s1_idx[lhc_pkg::BIN_W-1:0] == s1_bin)) begin
      bin_report = bin_new;
    end else begin
      bin_report = idx_cur;
    end
  end

  always_comb begin
    result.sample_count = count_next;
    result.latency_sum  = sum_next;
    result.min_latency  = min_lat_next;
    result.max_latency  = max_lat_next;
    result.bin_count    = bin_report;
    result.bin_echo     = s1_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_last  <= 1'b0;
      clr_last <= 1'b0;
      vbits    <= '0;
      count    <= '0;
      sum      <= '0;
      min_lat  <= '0;
      max_lat  <= '0;
    end else begin
      s1_valid <= accept;
      wr_last  <= ram_we;
      clr_last <= is_clear;
      count    <= count_next;
      sum      <= sum_next;
      min_lat  <= min_lat_next;
      max_lat  <= max_lat_next;
      if (is_clear) begin
        vbits <= '0;
      end else if (ram_we) begin
        vbits[s1_bin] <= 1'b1;
      end
    end
  end

  lhc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (result),
    .count     (fifo_count),
    .rsp       (rsp)
  );

endmodule

[bench/latency_histogram_collector_tb.sv]
// Self-checking bench for latency_histogram_collector: bursty requests against a stalling
// receiver, every result checked field by field against an in-bench statistics model.
// Depends on lhc_pkg, lhc_req_if, lhc_rsp_if and the collector RTL.
module latency_histogram_collector_tb;

  localparam lhc_pkg::op_t OP_READ  = 2'd1;
  localparam lhc_pkg::op_t OP_SPARE = 2'd3;
  localparam int  RANDOM_ITEMS = 1700;
  localparam int  CYCLE_LIMIT  = 300000;
  localparam int  DRAIN_CYCLES = 8;
  localparam int  HOLD_CYCLES  = 90;

  typedef struct {
    lhc_pkg::op_t  op;
    lhc_pkg::lat_t latency;
    lhc_pkg::idx_t bin_index;
    bit            wait_idle;
  } req_item_t;

  logic clk = 1'b0;
  logic rst;

  lhc_req_if req_ch ();
  lhc_rsp_if rsp_ch ();

  latency_histogram_collector uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Model of the collector's statistics.
  lhc_pkg::cnt_t st_count;
  lhc_pkg::sum_t st_sum;
  lhc_pkg::lat_t st_min;
  lhc_pkg::lat_t st_max;
  lhc_pkg::cnt_t st_bins [lhc_pkg::NUM_BINS];

  req_item_t     req_backlog [$];
  lhc_pkg::rsp_t stats_due [$];
  lhc_pkg::rsp_t want;

  int  cycles = 0;
  int  accepted = 0;
  int  checked = 0;
  int  errors = 0;
  int  n_record = 0;
  int  n_read = 0;
  int  n_clear = 0;
  bit  took = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_mode = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  int  holds_done = 0;

  function automatic lhc_pkg::lat_t bin_edge(int b);
    case (b)
      0: return 32'd10;
      1: return 32'd50;
      2: return 32'd100;
      3: return 32'd200;
      4: return 32'd500;
      5: return 32'd1000;
      6: return 32'd2000;
      7: return 32'd3000;
      8: return 32'd4000;
      9: return 32'd5000;
      10: return 32'd6000;
      11: return 32'd7000;
      12: return 32'd8000;
      13: return 32'd9000;
      14: return 32'd10000;
      15: return 32'd20000;
      16: return 32'd40000;
      17: return 32'd60000;
      18: return 32'd80000;
      19: return 32'd100000;
      20: return 32'd200000;
      21: return 32'd300000;
      22: return 32'd400000;
      23: return 32'd500000;
      24: return 32'd600000;
      25: return 32'd700000;
      26: return 32'd800000;
      27: return 32'd900000;
      28: return 32'd1000000;
      29: return 32'd2000000;
      30: return 32'd4000000;
      31: return 32'd8000000;
      default: return '1;
    endcase
  endfunction

  // First bin whose upper edge covers the sample; the last bin takes the rest.
  function automatic int bin_for(lhc_pkg::lat_t lat);
    int b;
    b = lhc_pkg::NUM_BINS - 1;
    for (int k = lhc_pkg::NUM_BINS - 2; k >= 0; k--) begin
      if (lat <= bin_edge(k)) begin
        b = k;
      end
    end
    return b;
  endfunction

  function automatic lhc_pkg::cnt_t sat_step(lhc_pkg::cnt_t v);
    return (v == '1) ? v : v + lhc_pkg::cnt_t'(1);
  endfunction

  function automatic void clear_stats();
    st_count = '0;
    st_sum   = '0;
    st_min   = '0;
    st_max   = '0;
    for (int b = 0; b < lhc_pkg::NUM_BINS; b++) begin
      st_bins[b] = '0;
    end
  endfunction

  function automatic lhc_pkg::rsp_t update_stats(lhc_pkg::op_t op, lhc_pkg::lat_t lat,
                                                 lhc_pkg::idx_t idx);
    lhc_pkg::rsp_t r;
    int            b;
    if (op == lhc_pkg::OP_RECORD) begin
      b = bin_for(lat);
      st_count = sat_step(st_count);
      st_sum = st_sum + lhc_pkg::sum_t'(lat);
      // A zero minimum means unset, so a zero sample never sticks as the minimum.
      if (st_min == '0 || st_min > lat) begin
        st_min = lat;
      end
      if (st_max < lat) begin
        st_max = lat;
      end
      st_bins[b] = sat_step(st_bins[b]);
      n_record++;
    end else if (op == lhc_pkg::OP_CLEAR) begin
      clear_stats();
      n_clear++;
    end else begin
      n_read++;
    end
    r.sample_count = st_count;
    r.latency_sum  = st_sum;
    r.min_latency  = st_min;
    r.max_latency  = st_max;
    r.bin_count    = (idx < lhc_pkg::NUM_BINS) ? st_bins[idx] : '0;
    r.bin_echo     = idx;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    if (errors < 40) begin
      $display("cycle %0d: %s mismatch, got 0x%0h, expected 0x%0h", cycles, what, got, exp);
    end
    errors++;
  endtask

  task automatic check_stats(lhc_pkg::rsp_t exp);
    if (rsp_ch.sample_count !== exp.sample_count) begin
      report_mismatch("sample_count", rsp_ch.sample_count, exp.sample_count);
    end
    if (rsp_ch.latency_sum !== exp.latency_sum) begin
      report_mismatch("latency_sum", rsp_ch.latency_sum, exp.latency_sum);
    end
    if (rsp_ch.min_latency !== exp.min_latency) begin
      report_mismatch("min_latency", rsp_ch.min_latency, exp.min_latency);
    end
    if (rsp_ch.max_latency !== exp.max_latency) begin
      report_mismatch("max_latency", rsp_ch.max_latency, exp.max_latency);
    end
    if (rsp_ch.bin_count !== exp.bin_count) begin
      report_mismatch("bin_count", rsp_ch.bin_count, exp.bin_count);
    end
    if (rsp_ch.bin_echo !== exp.bin_echo) begin
      report_mismatch("bin_echo", rsp_ch.bin_echo, exp.bin_echo);
    end
  endtask

  task automatic add_req(lhc_pkg::op_t op, lhc_pkg::lat_t lat, lhc_pkg::idx_t idx, bit idle);
    req_item_t it;
    it.op = op;
    it.latency = lat;
    it.bin_index = idx;
    it.wait_idle = idle;
    req_backlog.push_back(it);
  endtask

  function automatic lhc_pkg::lat_t random_latency();
    case ($urandom_range(0, 5))
      0: return lhc_pkg::lat_t'($urandom_range(0, 20));
      1: return bin_edge($urandom_range(0, 31)) + lhc_pkg::lat_t'($urandom_range(0, 2))
                - lhc_pkg::lat_t'(1);
      2: return lhc_pkg::lat_t'($urandom);
      3: return lhc_pkg::lat_t'($urandom_range(0, 9000000));
      4: return '1 - lhc_pkg::lat_t'($urandom_range(0, 3));
      default: return lhc_pkg::lat_t'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic lhc_pkg::idx_t random_index();
    if ($urandom_range(0, 9) == 0) begin
      return lhc_pkg::idx_t'($urandom_range(lhc_pkg::NUM_BINS, 63));
    end
    return lhc_pkg::idx_t'($urandom_range(0, lhc_pkg::NUM_BINS - 1));
  endfunction

  // Result checking and request prediction share one block so that the order
  // of queue pushes and pops within an edge is fixed.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      clear_stats();
      stats_due.delete();
      took <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (stats_due.size() == 0) begin
          report_mismatch("result with none expected", rsp_ch.bin_echo, '0);
        end else begin
          want = stats_due.pop_front();
          check_stats(want);
          checked++;
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        stats_due.push_back(update_stats(req_ch.op, req_ch.latency, req_ch.bin_index));
        accepted++;
      end
      took <= req_ch.valid && req_ch.ready;
    end
  end

  // Sender: bursts of items separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || took) begin
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (req_backlog.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (req_backlog[0].wait_idle && stats_due.size() != 0) begin
        req_ch.valid <= 1'b0;
      end else begin
        req_ch.valid     <= 1'b1;
        req_ch.op        <= req_backlog[0].op;
        req_ch.latency   <= req_backlog[0].latency;
        req_ch.bin_index <= req_backlog[0].bin_index;
        void'(req_backlog.pop_front());
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 3) == 0) begin
            gap_left = 0;
          end else if ($urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(5, 12);
          end else begin
            gap_left = $urandom_range(1, 3);
          end
        end
      end
    end
  end

  // Receiver: stall modes that change now and then, plus two long hold-offs
  // that let the result queue fill and push back on the request side.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_done < 2 && accepted >= 500 + 700 * holds_done) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
          2: rsp_ch.ready <= ($urandom_range(0, 4) != 0);
          default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    $display("timeout after %0d cycles", cycles);
    $display("latency_histogram_collector_tb: FAIL");
    $finish;
  end

  initial begin
    int            sel;
    lhc_pkg::lat_t lat;
    lhc_pkg::lat_t last_lat;
    lhc_pkg::idx_t idx;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = OP_READ;
    req_ch.latency = '0;
    req_ch.bin_index = '0;
    rsp_ch.ready = 1'b0;

    // Directed: empty reads, zero sample, bin edges, top of range, out-of-range
    // bins, the unused code and clears.
    add_req(OP_READ, 32'd0, 6'd0, 1'b0);
    add_req(lhc_pkg::OP_RECORD, 32'd0, 6'd0, 1'b0);
    add_req(OP_READ, 32'd0, 6'd0, 1'b0);
    add_req(lhc_pkg::OP_RECORD, 32'd10, 6'd0, 1'b0);
    add_req(lhc_pkg::OP_RECORD, 32'd11, 6'd1, 1'b0);
    add_req(lhc_pkg::OP_RECORD, 32'd1, 6'd0, 1'b0);
    add_req(lhc_pkg::OP_RECORD, 32'd50, 6'd1, 1'b0);
    add_req(lhc_pkg::OP_RECORD, 32'd51, 6'd2, 1'b0);
    add_req(lhc_pkg::OP_RECORD, 32'd4000000, 6'd30, 1'b0);
    add_req(lhc_pkg::OP_RECORD, 32'd8000000, 6'd31, 1'b0);
    add_req(lhc_pkg::OP_RECORD, 32'd8000001, 6'd32, 1'b0);
    add_req(lhc_pkg::OP_RECORD, 32'hFFFF_FFFF, 6'd32, 1'b0);
    add_req(OP_READ, 32'hFFFF_FFFF, 6'd32, 1'b0);
    add_req(OP_READ, 32'd0, 6'd33, 1'b0);
    add_req(OP_READ, 32'd0, 6'd63, 1'b0);
    add_req(OP_SPARE, 32'hFFFF_FFFF, 6'd1, 1'b0);
    add_req(lhc_pkg::OP_CLEAR, 32'd77, 6'd0, 1'b0);
    add_req(OP_READ, 32'd0, 6'd32, 1'b0);
    add_req(lhc_pkg::OP_RECORD, 32'd5, 6'd0, 1'b0);
    add_req(lhc_pkg::OP_RECORD, 32'd0, 6'd0, 1'b0);
    add_req(lhc_pkg::OP_CLEAR, 32'd0, 6'd40, 1'b1);
    add_req(lhc_pkg::OP_RECORD, 32'd0, 6'd0, 1'b0);
    add_req(OP_READ, 32'd0, 6'd0, 1'b0);
    add_req(lhc_pkg::OP_RECORD, 32'd7, 6'd0, 1'b0);

    last_lat = '0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 199);
      if (sel < 2) begin
        add_req(lhc_pkg::OP_CLEAR, lhc_pkg::lat_t'($urandom), random_index(), 1'b0);
      end else if (sel < 8) begin
        add_req(OP_SPARE, lhc_pkg::lat_t'($urandom), random_index(), 1'b0);
      end else if (sel < 50) begin
        // Reading the bin that was just written exercises the forwarding path.
        idx = ($urandom_range(0, 1) == 0) ? lhc_pkg::idx_t'(bin_for(last_lat))
                                          : random_index();
        add_req(OP_READ, lhc_pkg::lat_t'($urandom), idx, (i == 600 || i == 1300));
      end else begin
        lat = random_latency();
        idx = ($urandom_range(0, 1) == 0) ? lhc_pkg::idx_t'(bin_for(lat)) : random_index();
        add_req(lhc_pkg::OP_RECORD, lat, idx, (i == 600 || i == 1300));
        last_lat = lat;
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_backlog.size() != 0 || req_ch.valid || stats_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results from %0d records, %0d reads and %0d clears",
             checked, n_record, n_read, n_clear);
    $display("%0d long receiver hold-offs, %0d mismatches", holds_done, errors);
    if (errors == 0) begin
      $display("latency_histogram_collector_tb: PASS");
    end else begin
      $display("latency_histogram_collector_tb: FAIL");
    end
    $finish;
  end

endmodule
